/* src/bfd_pkg.sv */
// Shared types and field kind codes for the binary field decoder.
`default_nettype none

package bfd_pkg;

    // Field kinds: big-endian integers, then LEB128
    localparam logic [3:0] KIND_U8     = 4'd0;
    localparam logic [3:0] KIND_S8     = 4'd1;
    localparam logic [3:0] KIND_U16    = 4'd2;
    localparam logic [3:0] KIND_S16    = 4'd3;
    localparam logic [3:0] KIND_U32    = 4'd4;
    localparam logic [3:0] KIND_S32    = 4'd5;
    localparam logic [3:0] KIND_U64    = 4'd6;
    localparam logic [3:0] KIND_S64    = 4'd7;
    localparam logic [3:0] KIND_ULEB32 = 4'd8;
    localparam logic [3:0] KIND_ULEB64 = 4'd9;
    localparam logic [3:0] KIND_SLEB32 = 4'd10;
    localparam logic [3:0] KIND_SLEB64 = 4'd11;

    localparam logic [6:0] LEB_GROUP_BITS = 7'd7;
    localparam logic [6:0] LEB_WIDTH_32   = 7'd32;
    localparam logic [6:0] LEB_WIDTH_64   = 7'd64;
    localparam logic [3:0] BYTES_MAX      = 4'd15;

    localparam int VALUE_W = 64;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [6:0]         shift;
        logic [3:0]         bytes;
        logic               active;
        logic [3:0]         kind;
    } state_t;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] data_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        logic               emit;
        logic [VALUE_W-1:0] value;
        logic               error;
    } result_t;

endpackage

`default_nettype wire

/* src/bfd_step.sv */
// Per-item decode step: next field state and optional result.
`default_nettype none

module bfd_step (
    input  bfd_pkg::state_t  state,
    input  bfd_pkg::item_t   item,
    output bfd_pkg::state_t  state_next,
    output bfd_pkg::result_t result
);
    import bfd_pkg::*;

    logic [3:0]         kind;
    logic               start_ok;
    logic [3:0]         bytes_inc;
    logic [VALUE_W-1:0] be_acc;
    logic [4:0]         be_need;
    logic [VALUE_W-1:0] be_value;
    logic [6:0]         leb_width;
    logic [VALUE_W-1:0] leb_mask;
    logic [VALUE_W-1:0] leb_acc;
    logic [7:0]         shift_sum;
    logic [6:0]         shift_inc;
    logic [VALUE_W-1:0] leb_value;
    logic [VALUE_W-1:0] sign_fill;

    assign kind     = state.active ? state.kind : item.func;
    assign start_ok = state.active || (item.func <= KIND_SLEB64);
    assign bytes_inc = (state.bytes < BYTES_MAX) ? state.bytes + 4'd1 : state.bytes;

    // Big-endian path
    assign be_acc  = {state.acc[VALUE_W-9:0], item.data_byte};
    assign be_need = 5'd1 << kind[2:1];

    always_comb begin
        unique case (kind[2:1])
            2'd0: be_value = kind[0] ? {{56{be_acc[7]}},  be_acc[7:0]}  : {56'd0, be_acc[7:0]};
            2'd1: be_value = kind[0] ? {{48{be_acc[15]}}, be_acc[15:0]} : {48'd0, be_acc[15:0]};
            2'd2: be_value = kind[0] ? {{32{be_acc[31]}}, be_acc[31:0]} : {32'd0, be_acc[31:0]};
            default: be_value = be_acc;
        endcase
    end

    // LEB128 path
    assign leb_width = kind[0] ? LEB_WIDTH_64 : LEB_WIDTH_32;
    assign leb_mask  = kind[0] ? {VALUE_W{1'b1}} : {32'd0, 32'hFFFF_FFFF};
    assign leb_acc   = (state.shift < leb_width)
                     ? ((state.acc | ({57'd0, item.data_byte[6:0]} << state.shift[5:0]))
                        & leb_mask)
                     : state.acc;
    assign shift_sum = {1'b0, state.shift} + {1'b0, LEB_GROUP_BITS};
    assign shift_inc = (shift_sum > {1'b0, LEB_WIDTH_64}) ? LEB_WIDTH_64 : shift_sum[6:0];
    assign sign_fill = {VALUE_W{1'b1}} << shift_inc[5:0];

    always_comb begin
        leb_value = leb_acc;
        // signed kinds: fill above the last group, then for the 32-bit kind widen from bit 31
        if (kind >= KIND_SLEB32) begin
            if (shift_inc < leb_width && item.data_byte[6]) begin
                leb_value = (leb_value | sign_fill) & leb_mask;
            end
            if (!kind[0] && leb_value[31]) begin
                leb_value[63:32] = 32'hFFFF_FFFF;
            end
        end
    end

    always_comb begin
        state_next = state;
        result     = '0;
        if (item.stream_end) begin
            state_next.acc    = '0;
            state_next.shift  = '0;
            state_next.bytes  = '0;
            state_next.active = 1'b0;
            result.emit       = 1'b1;
            result.error      = 1'b1;
        end else if (start_ok) begin
            state_next.active = 1'b1;
            state_next.kind   = kind;
            state_next.bytes  = bytes_inc;
            if (!kind[3]) begin
                state_next.acc = be_acc;
                if ({1'b0, bytes_inc} >= be_need) begin
                    result.emit  = 1'b1;
                    result.value = be_value;
                end
            end else begin
                state_next.acc   = leb_acc;
                state_next.shift = shift_inc;
                if (!item.data_byte[7]) begin
                    result.emit  = 1'b1;
                    result.value = leb_value;
                end
            end
            // completed field: return to idle
            if (result.emit) begin
                state_next.acc    = '0;
                state_next.shift  = '0;
                state_next.bytes  = '0;
                state_next.active = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* src/binary_field_decoder.sv */
// Top level of the binary field decoder: input register, decode step, result register.
`default_nettype none

// Decodes a byte stream into big-endian (1, 2, 4, 8 byte, signed or unsigned) and
// LEB128 (32 or 64 bit, signed or unsigned) integer fields, one byte per item. The
// field kind is taken from s_func on a field's first byte; kinds 12 to 15 on a first
// byte are dropped without a result. A completed field gives one result with
// m_error low; an item with s_stream_end high always gives a result of value 0 with
// m_error high and abandons any field in progress. Each item passes through an
// input register and the combinational decode step into the result register, so
// the block takes one item per cycle while m_ready does not stall the output; the
// field state (accumulator, shift, byte count) is written at the same edge as the
// result register, which lets consecutive bytes of one field follow back to back.
module binary_field_decoder (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [3:0]                   s_func,
    input  wire  [7:0]                   s_data_byte,
    input  wire                          s_stream_end,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [bfd_pkg::VALUE_W-1:0] m_value,
    output logic                         m_error
);
    import bfd_pkg::*;

    logic             in_valid_reg;
    item_t            item_reg;
    state_t           state_reg;
    state_t           state_next;
    result_t          result;
    logic             out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic             error_reg;
    logic             advance;

    bfd_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.func       <= s_func;
            item_reg.data_byte  <= s_data_byte;
            item_reg.stream_end <= s_stream_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.emit) begin
            value_reg <= result.value;
            error_reg <= result.error;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_value = value_reg;
    assign m_error = error_reg;

endmodule

`default_nettype wire
